// File: rtl/osm_pkg.sv
// Shared types and constants for the order statistics block.
// No dependencies; every other file of the block imports this package.
package osm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_SAMPLES = 256;
	localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Input word: one sample and the end-of-set mark.
	typedef struct packed {
		sample_t sample;
		logic    last;
	} in_word_t;

	// Result word, one per data set.
	typedef struct packed {
		logic signed [SAMPLE_BITS:0] median_twice;
		sample_t                     upper_quartile;
		sample_t                     most_frequent;
		logic [CNT_BITS-1:0]         sample_count;
		logic                        overflowed;
	} out_word_t;

	// What a cell shows its neighbors: its value, whether it holds a sample,
	// and whether it would give way to the sample being inserted.
	typedef struct packed {
		sample_t val;
		logic    occ;
		logic    gtx;
	} link_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		sample_t sample;
		logic    ins;
		logic    shift;
	} cell_cmd_t;

	// Scanner status seen by the top level.
	typedef struct packed {
		logic busy;
		logic step;
		logic fin;
	} scan_stat_t;

endpackage

// File: rtl/order_statistics_median_q3_mode.sv
// Order statistics (doubled median, upper quartile, mode) of a data set.
// Throughput: one sample word per cycle while a set is being filled.
// The result word is registered once the final scan ends; the scan shifts the
// chain once per kept sample and holds on the last one until the output slot
// is free, and the input is stalled while it runs.
// Reset clears the chain's occupied flags, the count and all handshakes.
module order_statistics_median_q3_mode #(
	parameter int CELLS = osm_pkg::MAX_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_stall,
	input  osm_pkg::in_word_t  data,
	output logic               result_valid,
	input  logic               result_stall,
	output osm_pkg::out_word_t result
);
	import osm_pkg::*;

	localparam int CW = $clog2(CELLS + 1);

	// The sorting chain. Cell 0 holds the smallest sample. On insert, every
	// cell whose sample is larger than the new one moves one place up, and
	// the new sample lands in the gap. During the final scan the chain shifts
	// toward cell 0, which feeds the scanner one sorted sample per cycle (the
	// last held until the output slot is free) and empties the chain as it goes.
	link_t     link [CELLS];
	cell_cmd_t cmd;

	logic          accept, full, ins;
	logic [CW-1:0] count_q, count_nx;
	logic          ovf_q;

	scan_stat_t stat;
	out_word_t  res;
	logic       out_free;
	logic       result_valid_q;
	out_word_t  result_q;

	// New words are refused only while a finished set is being scanned.
	assign data_stall = stat.busy;
	assign accept     = data_valid && !data_stall;

	// The top cell being occupied means the set is at capacity: the word is
	// dropped and remembered as an overflow for this set.
	assign full     = link[CELLS-1].occ;
	assign ins      = accept && !full;
	assign count_nx = count_q + CW'(ins);

	assign cmd.sample = data.sample;
	assign cmd.ins    = ins;
	assign cmd.shift  = stat.step;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		link_t left, right;

		if (i == 0) begin : g_first
			assign left = '{val: '0, occ: 1'b1, gtx: 1'b0};
		end else begin : g_mid_l
			assign left = link[i-1];
		end

		if (i == CELLS - 1) begin : g_top
			assign right = '{val: '0, occ: 1'b0, gtx: 1'b1};
		end else begin : g_mid_r
			assign right = link[i+1];
		end

		osm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left),
			.right  (right),
			.link   (link[i])
		);
	end

	// Fill count and overflow flag of the set in progress. Both return to
	// zero when the last word of the set is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			count_q <= data.last ? '0 : count_nx;
			ovf_q   <= data.last ? 1'b0 : (ovf_q | full);
		end
	end

	osm_scan #(
		.CELLS (CELLS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && data.last),
		.count    (count_nx),
		.ovf      (ovf_q | full),
		.head     (link[0].val),
		.out_free (out_free),
		.stat     (stat),
		.res      (res)
	);

	// Output register. The scan holds on its final sample until this slot
	// is free, so a waiting result is never overwritten.
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (stat.fin) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.fin) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/osm_cell.sv
// One cell of the sorting chain: holds one sample and its occupied flag.
// Depends on osm_pkg.
module osm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  osm_pkg::cell_cmd_t cmd,
	input  osm_pkg::link_t     left,
	input  osm_pkg::link_t     right,
	output osm_pkg::link_t     link
);
	import osm_pkg::*;

	sample_t val_q;
	logic    occ_q;

	// An empty cell counts as larger than any sample, so the first empty
	// cell takes the new sample when nothing to its left gives way.
	assign link.val = val_q;
	assign link.occ = occ_q;
	assign link.gtx = !occ_q || (val_q > cmd.sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.ins) begin
			occ_q <= occ_q | left.occ;
		end else if (cmd.shift) begin
			occ_q <= right.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			val_q <= left.gtx ? left.val : (link.gtx ? cmd.sample : val_q);
		end else if (cmd.shift) begin
			val_q <= right.val;
		end
	end

endmodule

// File: rtl/osm_scan.sv
// Final scan: reads the sorted set off the chain head one sample per cycle,
// holding the last for a free output; forms median, Q3, mode. Uses osm_pkg.
module osm_scan #(
	parameter int CELLS = osm_pkg::MAX_SAMPLES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [$clog2(CELLS+1)-1:0]   count,
	input  logic                         ovf,
	input  osm_pkg::sample_t             head,
	input  logic                         out_free,
	output osm_pkg::scan_stat_t          stat,
	output osm_pkg::out_word_t           res
);
	import osm_pkg::*;

	localparam int CW = $clog2(CELLS + 1);
	localparam int IW = $clog2(CELLS);

	logic [CW-1:0] n_half;
	logic [CW:0]   n_plus, mid, half, qi_w, qi_c;
	logic [IW-1:0] lo_idx, hi_idx, q_idx;

	logic          busy_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] lo_idx_q, hi_idx_q, q_idx_q;
	logic          ovf_q;
	sample_t       prev_q, best_q, lo_q, hi_q, qv_q;
	logic [CW-1:0] run_q, best_run_q;

	logic          last_k, first_k, step, take;
	logic [CW-1:0] run_nx, best_run_nx;
	sample_t       best_nx, lo_nx, hi_nx, qv_nx;

	// Index arithmetic on the set size, done once when the set closes.
	always_comb begin
		n_half = count >> 1;
		n_plus = (CW+1)'(count) + (CW+1)'(1);
		mid    = (n_plus >> 1) - (CW+1)'(1);
		half   = (CW+1)'(count) - (CW+1)'(1) - mid;
		qi_w   = mid + ((half + (CW+1)'(1)) >> 1);
		qi_c   = (qi_w >= (CW+1)'(count)) ? (CW+1)'(count) - (CW+1)'(1) : qi_w;
		q_idx  = qi_c[IW-1:0];
		hi_idx = n_half[IW-1:0];
		lo_idx = count[0] ? n_half[IW-1:0] : n_half[IW-1:0] - IW'(1);
	end

	assign last_k  = (CW'(k_q) == count_q - CW'(1));
	assign first_k = (k_q == '0);
	assign step    = busy_q && (!last_k || out_free);

	// Run-length tracking of equal neighbors; a strictly longer run wins, so
	// the smallest value keeps a tie.
	always_comb begin
		run_nx      = (first_k || head != prev_q) ? CW'(1) : run_q + CW'(1);
		take        = first_k || (run_nx > best_run_q);
		best_nx     = take ? head : best_q;
		best_run_nx = take ? run_nx : best_run_q;
		lo_nx       = (k_q == lo_idx_q) ? head : lo_q;
		hi_nx       = (k_q == hi_idx_q) ? head : hi_q;
		qv_nx       = (k_q == q_idx_q) ? head : qv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (step && last_k) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q      <= '0;
			count_q  <= count;
			lo_idx_q <= lo_idx;
			hi_idx_q <= hi_idx;
			q_idx_q  <= q_idx;
			ovf_q    <= ovf;
		end else if (step) begin
			k_q        <= last_k ? k_q : k_q + IW'(1);
			prev_q     <= head;
			run_q      <= run_nx;
			best_q     <= best_nx;
			best_run_q <= best_run_nx;
			lo_q       <= lo_nx;
			hi_q       <= hi_nx;
			qv_q       <= qv_nx;
		end
	end

	assign stat.busy = busy_q;
	assign stat.step = step;
	assign stat.fin  = step && last_k;

	assign res.median_twice   = {lo_nx[SAMPLE_BITS-1], lo_nx} + {hi_nx[SAMPLE_BITS-1], hi_nx};
	assign res.upper_quartile = qv_nx;
	assign res.most_frequent  = best_nx;
	assign res.sample_count   = CNT_BITS'(count_q);
	assign res.overflowed     = ovf_q;

endmodule

// File: rtl/osm_checker.sv
// Port-level checks for the order statistics block, bound to its top level.
// Depends on osm_pkg and order_statistics_median_q3_mode.
module osm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               data_valid,
	input logic               data_stall,
	input osm_pkg::in_word_t  data,
	input logic               result_valid,
	input logic               result_stall,
	input osm_pkg::out_word_t result
);
	import osm_pkg::*;

	// Closing a set starts the scan, whose registered busy flag stalls the input.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_stall && data.last |=> data_stall)
		else $error("input not stalled after the last word of a set");

	// A result only comes out of a scan, while the input was stalled.
	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(data_stall))
		else $error("result word appeared without a scan");

	// Every set keeps at least one sample.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.sample_count != '0)
		else $error("result word with zero samples");

	// A stalled result word holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

endmodule

bind order_statistics_median_q3_mode osm_checker u_osm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.data_valid   (data_valid),
	.data_stall   (data_stall),
	.data         (data),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
